// ----- rtl/serial_command_frame_handler_top_defines.svh -----
// assertion macros shared by the serial command frame handler rtl
`ifndef SERIAL_COMMAND_FRAME_HANDLER_TOP_DEFINES_SVH
`define SERIAL_COMMAND_FRAME_HANDLER_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising clk edge out of reset
`define SCFH_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scfh assertion failed");

// next-cycle implication, checked on every rising clk edge out of reset
`define SCFH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scfh assertion failed");

`endif

// ----- rtl/scfh_pkg.sv -----
// types and constants of the serial command frame handler
`default_nettype none

package scfh_pkg;

  localparam int unsigned BURST_BYTES = 20;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned IDX_W       = 5;

  localparam logic [7:0] HEADER_BYTE = 8'hAA;
  localparam logic [7:0] TAIL_BYTE   = 8'h55;

  localparam logic [7:0] CMD_REPORT    = 8'h01;
  localparam logic [7:0] CMD_PERIOD    = 8'h02;
  localparam logic [7:0] CMD_THRESHOLD = 8'h03;
  localparam logic [7:0] CMD_LED       = 8'h04;
  localparam logic [7:0] CMD_HISTORY   = 8'h05;
  localparam logic [7:0] CMD_ALARM     = 8'h06;

  localparam logic [7:0] PERIOD_MAX    = 8'd60;
  localparam logic [7:0] THRESHOLD_MAX = 8'd127;
  localparam logic [7:0] LED_MAX       = 8'd2;

  localparam logic [IDX_W-1:0] MIN_FRAME_LEN = 5'd5;

  localparam logic [5:0] PERIOD_RESET    = 6'd1;
  localparam logic [6:0] THRESHOLD_RESET = 7'd30;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_FRAME = 2'd1,
    PH_DONE  = 2'd2,
    PH_DROP  = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    RSP_LED       = 4'd0,
    RSP_CHECK_ERR = 4'd1,
    RSP_OK        = 4'd2,
    RSP_RANGE_ERR = 4'd3,
    RSP_REPORT    = 4'd4,
    RSP_HISTORY   = 4'd5,
    RSP_ALARM_ON  = 4'd6,
    RSP_ALARM_OFF = 4'd7,
    RSP_UNKNOWN   = 4'd8
  } resp_t;

endpackage

`default_nettype wire

// ----- rtl/serial_command_frame_handler_top.sv -----
// serial command frame handler: frame parser, command execution and result register
//
// channel | dir | tdata                                   | tuser
// s_*     | in  | [7:0] rx_byte                           | command (1 = line idle)
// m_*     | out | [3:0] response_code [9:4] sample_period  | -
//         |     | [16:10] alarm_threshold [18:17] led_mode |
//         |     | [19] alarm_enabled [23:20] zero          |
//
// one item per cycle unless a result stalls: an input register feeds one step of parse or execute
// logic that writes the burst state and, at line idle, the result register
// for an idle item, the input register and then the result register lie between input accept and result valid
// s_tready drops only while an idle item waits behind an untaken result
// rst is synchronous: burst state cleared, settings back to period 1, threshold 30
`default_nettype none
`include "serial_command_frame_handler_top_defines.svh"

module serial_command_frame_handler_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [3:0] code, [9:4] period, [16:10] threshold,
                                 // [18:17] led, [19] alarm, [23:20] zero
);

  // input register
  logic       in_valid;
  logic       in_cmd;
  logic [7:0] in_byte;
  logic       advance;

  // burst state
  logic [scfh_pkg::POS_W-1:0] burst_position, burst_position_next;
  scfh_pkg::phase_t           phase, phase_next;
  logic [scfh_pkg::IDX_W-1:0] frame_index, frame_index_next;
  logic [7:0]                 running_xor, running_xor_next;
  logic [7:0]                 command_byte, command_byte_next;
  logic [7:0]                 argument_byte, argument_byte_next;

  // settings
  logic [5:0] period_setting, period_setting_next;
  logic [6:0] threshold_setting, threshold_setting_next;
  logic [1:0] led_setting, led_setting_next;
  logic       alarm_setting, alarm_setting_next;

  logic              take_en;
  logic              emit;
  logic              frame_ok;
  scfh_pkg::resp_t   code;
  scfh_pkg::resp_t   exec_code;
  logic              header_late;

  // result register
  scfh_pkg::resp_t out_code;
  logic [5:0]      out_period;
  logic [6:0]      out_threshold;
  logic [1:0]      out_led;
  logic            out_alarm;

  // byte items never wait; an idle item waits only for a free result register
  assign advance  = in_valid && (!in_cmd || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_cmd  <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  assign take_en = advance && !in_cmd &&
                   (burst_position < scfh_pkg::POS_W'(scfh_pkg::BURST_BYTES));
  assign emit    = advance && in_cmd && (phase == scfh_pkg::PH_FRAME ||
                                         phase == scfh_pkg::PH_DONE);
  assign frame_ok = (phase == scfh_pkg::PH_DONE) &&
                    (frame_index >= scfh_pkg::MIN_FRAME_LEN) && (running_xor == 8'h00);
  assign header_late = ({1'b0, burst_position} + 6'd6) > 6'(scfh_pkg::BURST_BYTES);

  // next phase
  always_comb begin
    phase_next = phase;
    if (advance && in_cmd) begin
      phase_next = scfh_pkg::PH_HUNT;
    end else if (take_en) begin
      unique case (phase)
        scfh_pkg::PH_HUNT: begin
          if (in_byte == scfh_pkg::HEADER_BYTE) begin
            phase_next = header_late ? scfh_pkg::PH_DROP : scfh_pkg::PH_FRAME;
          end
        end
        scfh_pkg::PH_FRAME: begin
          if (in_byte == scfh_pkg::TAIL_BYTE) begin
            phase_next = scfh_pkg::PH_DONE;
          end
        end
        scfh_pkg::PH_DONE,
        scfh_pkg::PH_DROP: phase_next = phase;
        default:           phase_next = phase;
      endcase
    end
  end

  // burst datapath
  always_comb begin
    burst_position_next = burst_position;
    frame_index_next    = frame_index;
    running_xor_next    = running_xor;
    command_byte_next   = command_byte;
    argument_byte_next  = argument_byte;
    if (advance && in_cmd) begin
      burst_position_next = '0;
      frame_index_next    = '0;
      running_xor_next    = '0;
      command_byte_next   = '0;
      argument_byte_next  = '0;
    end else if (take_en) begin
      burst_position_next = burst_position + 1'b1;
      if (phase == scfh_pkg::PH_HUNT) begin
        if (in_byte == scfh_pkg::HEADER_BYTE && !header_late) begin
          frame_index_next = scfh_pkg::IDX_W'(1);
        end
      end else if (phase == scfh_pkg::PH_FRAME) begin
        frame_index_next = frame_index + 1'b1;
        if (in_byte != scfh_pkg::TAIL_BYTE) begin
          if (frame_index >= scfh_pkg::IDX_W'(2)) begin
            running_xor_next = running_xor ^ in_byte;
          end
          if (frame_index == scfh_pkg::IDX_W'(2)) begin
            command_byte_next = in_byte;
          end
          if (frame_index == scfh_pkg::IDX_W'(3)) begin
            argument_byte_next = in_byte;
          end
        end
      end
    end
  end

  // command execution
  always_comb begin
    period_setting_next    = period_setting;
    threshold_setting_next = threshold_setting;
    led_setting_next       = led_setting;
    alarm_setting_next     = alarm_setting;
    exec_code              = scfh_pkg::RSP_UNKNOWN;
    unique case (command_byte)
      scfh_pkg::CMD_REPORT: exec_code = scfh_pkg::RSP_REPORT;
      scfh_pkg::CMD_PERIOD: begin
        if (argument_byte != 8'd0 && argument_byte <= scfh_pkg::PERIOD_MAX) begin
          period_setting_next = argument_byte[5:0];
          exec_code           = scfh_pkg::RSP_OK;
        end else begin
          exec_code = scfh_pkg::RSP_RANGE_ERR;
        end
      end
      scfh_pkg::CMD_THRESHOLD: begin
        if (argument_byte != 8'd0 && argument_byte <= scfh_pkg::THRESHOLD_MAX) begin
          threshold_setting_next = argument_byte[6:0];
          exec_code              = scfh_pkg::RSP_OK;
        end else begin
          exec_code = scfh_pkg::RSP_RANGE_ERR;
        end
      end
      scfh_pkg::CMD_LED: begin
        // out-of-range mode keeps the led as is but still answers with the led code, not a range error
        if (argument_byte <= scfh_pkg::LED_MAX) begin
          led_setting_next = argument_byte[1:0];
        end
        exec_code = scfh_pkg::RSP_LED;
      end
      scfh_pkg::CMD_HISTORY: exec_code = scfh_pkg::RSP_HISTORY;
      scfh_pkg::CMD_ALARM: begin
        alarm_setting_next = (argument_byte == 8'd1);
        exec_code = (argument_byte == 8'd1) ? scfh_pkg::RSP_ALARM_ON
                                            : scfh_pkg::RSP_ALARM_OFF;
      end
      default: exec_code = scfh_pkg::RSP_UNKNOWN;
    endcase
    if (!frame_ok) begin
      period_setting_next    = period_setting;
      threshold_setting_next = threshold_setting;
      led_setting_next       = led_setting;
      alarm_setting_next     = alarm_setting;
    end
  end

  assign code = frame_ok ? exec_code : scfh_pkg::RSP_CHECK_ERR;

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_position    <= '0;
      phase             <= scfh_pkg::PH_HUNT;
      frame_index       <= '0;
      running_xor       <= '0;
      command_byte      <= '0;
      argument_byte     <= '0;
      period_setting    <= scfh_pkg::PERIOD_RESET;
      threshold_setting <= scfh_pkg::THRESHOLD_RESET;
      led_setting       <= 2'd0;
      alarm_setting     <= 1'b0;
      m_tvalid          <= 1'b0;
    end else begin
      burst_position <= burst_position_next;
      phase          <= phase_next;
      frame_index    <= frame_index_next;
      running_xor    <= running_xor_next;
      command_byte   <= command_byte_next;
      argument_byte  <= argument_byte_next;
      if (emit) begin
        period_setting    <= period_setting_next;
        threshold_setting <= threshold_setting_next;
        led_setting       <= led_setting_next;
        alarm_setting     <= alarm_setting_next;
        m_tvalid          <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_code      <= code;
      out_period    <= period_setting_next;
      out_threshold <= threshold_setting_next;
      out_led       <= led_setting_next;
      out_alarm     <= alarm_setting_next;
    end
  end

  assign m_tdata = {4'b0000, out_alarm, out_led, out_threshold, out_period, out_code};

  `SCFH_ASSERT_IMPL(a_pos_bound, 1'b1,
                    burst_position <= scfh_pkg::POS_W'(scfh_pkg::BURST_BYTES))
  `SCFH_ASSERT_NEXT(a_idle_clears, advance && in_cmd,
                    burst_position == '0 && phase == scfh_pkg::PH_HUNT && running_xor == 8'h00)
  `SCFH_ASSERT_IMPL(a_hunt_clean, phase == scfh_pkg::PH_HUNT,
                    frame_index == '0 && running_xor == 8'h00)
  `SCFH_ASSERT_IMPL(a_settings_range, 1'b1,
                    period_setting != 6'd0 && period_setting <= 6'd60 &&
                    threshold_setting != 7'd0 && led_setting != 2'd3)
  `SCFH_ASSERT_IMPL(a_result_from_idle, $rose(m_tvalid), $past(emit))

endmodule

`default_nettype wire
